/* sv/trie_pkg.sv */
// Shared constants, codes and types for the lowercase trie block.
`default_nettype none
package trie_pkg;

  localparam int unsigned ALPHABET_DEF = 26;
  localparam int unsigned NODES_DEF    = 1024;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned USED_W   = 11;

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_WHOLE  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_PREFIX = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ALLOC,
    ST_LRD,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

/* sv/trie_if.sv */
// Valid/ready channel interfaces for the trie input items and result items.
`default_nettype none
interface trie_in_if import trie_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [LETTER_W-1:0] letter;
  logic                no_letter;
  logic                last;

  modport source (output valid, func, letter, no_letter, last, input ready);
  modport sink (input valid, func, letter, no_letter, last, output ready);
endinterface

interface trie_out_if import trie_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [USED_W-1:0]   nodes_used;

  modport source (output valid, found, status, nodes_used, input ready);
  modport sink (input valid, found, status, nodes_used, output ready);
endinterface
`default_nettype wire

/* sv/trie_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module trie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/trie_insert_and_lookup_top.sv */
// Top level of the lowercase trie: walk, insert and lookup over node memories.
// A letter item is accepted with its memory reads in ST_IDLE, walked in ST_EXEC, and also takes ST_ALLOC
// when it allocates a node. A last item goes on to read the node entry in ST_LRD and registers its
// result in ST_FIN, which waits for a free output; a new item is accepted only back in ST_IDLE.
// Reset clears the control state, the node count (root only) and the root entry registers.
// The memories are not cleared; a node entry is zeroed when the node is allocated.
`default_nettype none
module trie_insert_and_lookup_top import trie_pkg::*; #(
  parameter int unsigned ALPHABET = ALPHABET_DEF,
  parameter int unsigned NODES    = NODES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  trie_in_if.sink    in_ch,
  trie_out_if.source out_ch
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned AW = $clog2(NODES * ALPHABET);
  localparam int unsigned EW = ALPHABET + 1;

  state_t state_r, state_nxt;

  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [LETTER_W-1:0] letter_r, letter_nxt;
  logic                nolet_r, nolet_nxt;
  logic                last_r, last_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;

  logic [NW-1:0]       cur_r, cur_nxt;
  logic                failed_r, failed_nxt;
  logic [STATUS_W-1:0] fcode_r, fcode_nxt;
  logic [CW-1:0]       free_r, free_nxt;
  logic [ALPHABET-1:0] root_pres_r, root_pres_nxt;
  logic                root_end_r, root_end_nxt;
  logic [NW-1:0]       par_r, par_nxt;
  logic [EW-1:0]       wr_ent_r, wr_ent_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [USED_W-1:0]   out_used_r, out_used_nxt;

  logic                node_we, node_re;
  logic [NW-1:0]       node_waddr, node_raddr;
  logic [EW-1:0]       node_wdata, node_rdata;
  logic                cidx_we, cidx_re;
  logic [AW-1:0]       cidx_waddr, cidx_raddr;
  logic [NW-1:0]       cidx_wdata, cidx_rdata;

  logic                accept;
  logic                in_good;
  logic [AW-1:0]       slot_calc;
  logic [ALPHABET-1:0] cur_pres;
  logic                cur_end;
  logic [ALPHABET-1:0] mask;
  logic                good;
  logic                hit;
  logic                pool_full;
  logic                do_walk;
  logic                do_alloc;
  logic                out_free;
  logic                mark;
  logic                found_val;

  trie_ram #(.WIDTH(EW), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  trie_ram #(.WIDTH(NW), .DEPTH(NODES * ALPHABET)) u_cidx_ram (
    .clk   (clk),
    .we    (cidx_we),
    .waddr (cidx_waddr),
    .wdata (cidx_wdata),
    .re    (cidx_re),
    .raddr (cidx_raddr),
    .rdata (cidx_rdata)
  );

  // Walk decisions taken from the current node entry and the child slot read.
  always_comb begin
    accept    = in_ch.valid && (state_r == ST_IDLE);
    in_good   = 32'(in_ch.letter) < 32'(ALPHABET);
    slot_calc = AW'(cur_r) * AW'(ALPHABET) + AW'(in_ch.letter);
    cur_pres  = (cur_r == '0) ? root_pres_r : node_rdata[ALPHABET-1:0];
    cur_end   = (cur_r == '0) ? root_end_r : node_rdata[ALPHABET];
    mask      = ALPHABET'(1) << letter_r;
    good      = 32'(letter_r) < 32'(ALPHABET);
    hit       = |(cur_pres & mask);
    pool_full = free_r == CW'(NODES);
    do_walk   = !nolet_r && good && !failed_r;
    do_alloc  = do_walk && !hit && (func_r == OP_INSERT) && !pool_full;
    out_free  = !out_valid_r || out_ch.ready;
    mark      = !failed_r && (func_r == OP_INSERT);
    if (failed_r) begin
      found_val = 1'b0;
    end else if (func_r == OP_WHOLE) begin
      found_val = cur_end;
    end else begin
      found_val = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (do_alloc) begin
          state_nxt = ST_ALLOC;
        end else if (last_r) begin
          state_nxt = ST_LRD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        state_nxt = last_r ? ST_LRD : ST_IDLE;
      end
      ST_LRD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    node_we     = 1'b0;
    node_waddr  = cur_r;
    node_wdata  = '0;
    node_re     = 1'b0;
    node_raddr  = cur_r;
    cidx_we     = 1'b0;
    cidx_waddr  = slot_r;
    cidx_wdata  = NW'(free_r);
    cidx_re     = 1'b0;
    cidx_raddr  = slot_calc;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        node_re     = accept;
        cidx_re     = accept && in_good && !in_ch.no_letter;
      end
      ST_EXEC: begin
        node_we    = do_alloc;
        node_waddr = NW'(free_r);
        node_wdata = '0;
        cidx_we    = do_alloc;
      end
      ST_ALLOC: begin
        node_we    = par_r != '0;
        node_waddr = par_r;
        node_wdata = wr_ent_r;
      end
      ST_LRD: begin
        node_re = 1'b1;
      end
      ST_FIN: begin
        node_we    = out_free && mark && (cur_r != '0);
        node_waddr = cur_r;
        node_wdata = {1'b1, cur_pres};
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    func_nxt       = func_r;
    letter_nxt     = letter_r;
    nolet_nxt      = nolet_r;
    last_nxt       = last_r;
    slot_nxt       = slot_r;
    cur_nxt        = cur_r;
    failed_nxt     = failed_r;
    fcode_nxt      = fcode_r;
    free_nxt       = free_r;
    root_pres_nxt  = root_pres_r;
    root_end_nxt   = root_end_r;
    par_nxt        = par_r;
    wr_ent_nxt     = wr_ent_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt   = in_ch.func;
          letter_nxt = in_ch.letter;
          nolet_nxt  = in_ch.no_letter;
          last_nxt   = in_ch.last;
          slot_nxt   = slot_calc;
        end
      end
      ST_EXEC: begin
        if (!nolet_r) begin
          if (!good) begin
            if (fcode_r == STAT_OK) begin
              failed_nxt = 1'b1;
              fcode_nxt  = STAT_BAD;
            end
          end else if (!failed_r) begin
            if (hit) begin
              cur_nxt = cidx_rdata;
            end else if (func_r != OP_INSERT) begin
              failed_nxt = 1'b1;
            end else if (pool_full) begin
              failed_nxt = 1'b1;
              fcode_nxt  = STAT_FULL;
            end else begin
              par_nxt    = cur_r;
              wr_ent_nxt = {cur_end, cur_pres | mask};
              cur_nxt    = NW'(free_r);
              free_nxt   = free_r + CW'(1);
            end
          end
        end
      end
      ST_ALLOC: begin
        if (par_r == '0) begin
          root_pres_nxt = wr_ent_r[ALPHABET-1:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_val;
          out_status_nxt = fcode_r;
          out_used_nxt   = USED_W'(free_r);
          if (mark && (cur_r == '0)) begin
            root_end_nxt = 1'b1;
          end
          cur_nxt    = '0;
          failed_nxt = 1'b0;
          fcode_nxt  = STAT_OK;
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      failed_r    <= 1'b0;
      fcode_r     <= STAT_OK;
      free_r      <= CW'(1);
      root_pres_r <= '0;
      root_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      failed_r    <= failed_nxt;
      fcode_r     <= fcode_nxt;
      free_r      <= free_nxt;
      root_pres_r <= root_pres_nxt;
      root_end_r  <= root_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    letter_r     <= letter_nxt;
    nolet_r      <= nolet_nxt;
    last_r       <= last_nxt;
    slot_r       <= slot_nxt;
    par_r        <= par_nxt;
    wr_ent_r     <= wr_ent_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.nodes_used = out_used_r;

`ifndef SYNTH
  a_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(cur_r) < free_r)
    else $error("Current node is not an allocated node.");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r != '0) && (free_r <= CW'(NODES)))
    else $error("Node count left its range.");

  a_code_needs_fail: assert property (@(posedge clk) disable iff (!rst_n)
    !failed_r |-> (fcode_r == STAT_OK))
    else $error("Error code recorded without a failed word.");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("Result loaded outside the result state.");
`endif

endmodule
`default_nettype wire
